>>> design/sfpr_pkg.sv
// Shared types, byte codes and helpers for the serial frame parser/responder.
// Used by every module of the block; no dependencies.
package sfpr_pkg;

  // Frame characters
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Command codes
  localparam logic [7:0] CMD_SEND = 8'hA0;
  localparam logic [7:0] CMD_NACK = 8'hA1;
  localparam logic [7:0] CMD_ACK  = 8'h0D;

  // Reply frame
  localparam logic [7:0] REPLY_TAG = 8'h06;
  localparam logic [7:0] REPLY_LEN_HI = 8'h00;
  localparam int         REPLY_LEN = 13;
  localparam int         IDX_W     = $clog2(REPLY_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPLY_LEN - 1);

  // Byte positions within the reply frame
  localparam logic [IDX_W-1:0] POS_U    = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_N    = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_E    = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_R    = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_TAG  = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_LHI  = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_COL  = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_CMD  = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_A_LO = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_A_HI = IDX_W'(9);
  localparam logic [IDX_W-1:0] POS_B_LO = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_B_HI = IDX_W'(11);
  localparam logic [IDX_W-1:0] POS_SUM  = IDX_W'(12);

  // XOR of the fixed reply bytes ahead of the channel data
  localparam logic [7:0] REPLY_HDR_XOR =
    CH_U ^ CH_N ^ CH_E ^ CH_R ^ REPLY_TAG ^ REPLY_LEN_HI ^ CH_COLON ^ CMD_SEND;

  // XOR of the fixed request header letters and the colon
  localparam logic [7:0] RX_HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  // Input operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_GOT_U  = 3'd1,
    PH_GOT_N  = 3'd2,
    PH_GOT_E  = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_LEN_HI = 3'd5,
    PH_COLON  = 3'd6,
    PH_BODY   = 3'd7
  } phase_t;

  // Parser results seen by the reply stage
  typedef struct packed {
    logic        ack;
    logic [15:0] chan_a;
    logic [15:0] chan_b;
  } parse_status_t;

  // Reply stage status seen by the input stage
  typedef struct packed {
    logic free;
  } reply_status_t;

  // Checksum of a reply frame for the given channels
  function automatic logic [7:0] reply_sum(input logic [15:0] a, input logic [15:0] b);
    reply_sum = REPLY_HDR_XOR ^ a[7:0] ^ a[15:8] ^ b[7:0] ^ b[15:8];
  endfunction

endpackage

>>> design/sfpr_parser.sv
// Frame parser state: header match, length count, running XOR, command
// handling, acknowledge flag and stored ADC channels. Uses sfpr_pkg.
module sfpr_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   op,
  input  logic [7:0]             rx_byte,
  input  logic [15:0]            adc_first,
  input  logic [15:0]            adc_second,
  output logic                   reply_req,
  output sfpr_pkg::parse_status_t status
);

  sfpr_pkg::phase_t phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  command_byte, command_byte_next;
  logic        command_seen, command_seen_next;
  logic [7:0]  length_high, length_high_next;
  logic        ack_state, ack_state_next;
  logic [15:0] channel_a, channel_a_next;
  logic [15:0] channel_b, channel_b_next;
  logic        frame_good;
  logic        miss_u;

  // A valid frame ends on this byte
  assign frame_good = (phase == sfpr_pkg::PH_BODY) && (bytes_left <= 8'd1) &&
                      (rx_byte == running_xor) && command_seen;
  assign miss_u = (rx_byte == sfpr_pkg::CH_U);

  // Next state of the parser
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    running_xor_next  = running_xor;
    command_byte_next = command_byte;
    command_seen_next = command_seen;
    length_high_next  = length_high;
    ack_state_next    = ack_state;
    channel_a_next    = channel_a;
    channel_b_next    = channel_b;
    if (op == sfpr_pkg::OP_LOAD) begin
      channel_a_next = adc_first;
      channel_b_next = adc_second;
    end else begin
      unique case (phase)
        sfpr_pkg::PH_HUNT: begin
          if (miss_u) phase_next = sfpr_pkg::PH_GOT_U;
        end
        sfpr_pkg::PH_GOT_U: begin
          if (rx_byte == sfpr_pkg::CH_N) phase_next = sfpr_pkg::PH_GOT_N;
          else phase_next = miss_u ? sfpr_pkg::PH_GOT_U : sfpr_pkg::PH_HUNT;
        end
        sfpr_pkg::PH_GOT_N: begin
          if (rx_byte == sfpr_pkg::CH_E) phase_next = sfpr_pkg::PH_GOT_E;
          else phase_next = miss_u ? sfpr_pkg::PH_GOT_U : sfpr_pkg::PH_HUNT;
        end
        sfpr_pkg::PH_GOT_E: begin
          if (rx_byte == sfpr_pkg::CH_R) phase_next = sfpr_pkg::PH_LEN_LO;
          else phase_next = miss_u ? sfpr_pkg::PH_GOT_U : sfpr_pkg::PH_HUNT;
        end
        sfpr_pkg::PH_LEN_LO: begin
          bytes_left_next = rx_byte;
          phase_next      = sfpr_pkg::PH_LEN_HI;
        end
        sfpr_pkg::PH_LEN_HI: begin
          length_high_next = rx_byte;
          phase_next       = sfpr_pkg::PH_COLON;
        end
        sfpr_pkg::PH_COLON: begin
          if (rx_byte == sfpr_pkg::CH_COLON) begin
            // seed the checksum with the header; a zero length counts as one
            running_xor_next  = sfpr_pkg::RX_HDR_XOR ^ bytes_left ^ length_high;
            if (bytes_left == 8'd0) bytes_left_next = 8'd1;
            command_seen_next = 1'b0;
            phase_next        = sfpr_pkg::PH_BODY;
          end else begin
            phase_next = miss_u ? sfpr_pkg::PH_GOT_U : sfpr_pkg::PH_HUNT;
          end
        end
        sfpr_pkg::PH_BODY: begin
          if (bytes_left > 8'd1) begin
            running_xor_next = running_xor ^ rx_byte;
            if (!command_seen) begin
              command_byte_next = rx_byte;
              command_seen_next = 1'b1;
            end
            bytes_left_next = bytes_left - 8'd1;
          end else begin
            bytes_left_next = 8'd0;
            phase_next      = sfpr_pkg::PH_HUNT;
            if (frame_good && command_byte == sfpr_pkg::CMD_ACK) ack_state_next = 1'b1;
            if (frame_good && command_byte == sfpr_pkg::CMD_NACK) ack_state_next = 1'b0;
          end
        end
        default: phase_next = sfpr_pkg::PH_HUNT;
      endcase
    end
  end

  // Outputs of the parser
  always_comb begin
    reply_req = (op == sfpr_pkg::OP_LOAD) ||
                (frame_good && command_byte == sfpr_pkg::CMD_SEND);
    status.ack    = ack_state;
    status.chan_a = channel_a;
    status.chan_b = channel_b;
  end

  // Advance parser state on each beat handed to the reply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sfpr_pkg::PH_HUNT;
      bytes_left   <= 8'd0;
      running_xor  <= 8'd0;
      command_byte <= 8'd0;
      command_seen <= 1'b0;
      length_high  <= 8'd0;
      ack_state    <= 1'b0;
      channel_a    <= 16'd0;
      channel_b    <= 16'd0;
    end else if (take) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      running_xor  <= running_xor_next;
      command_byte <= command_byte_next;
      command_seen <= command_seen_next;
      length_high  <= length_high_next;
      ack_state    <= ack_state_next;
      channel_a    <= channel_a_next;
      channel_b    <= channel_b_next;
    end
  end

endmodule

>>> design/sfpr_reply.sv
// Result register and reply serializer: holds the current result beat and
// steps through the 13-byte reply frame. Uses sfpr_pkg.
module sfpr_reply (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          reply_req,
  input  sfpr_pkg::parse_status_t       status,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          tx_valid,
  output logic [7:0]                    tx_byte,
  output logic                          last,
  output logic                          ack_flag,
  output sfpr_pkg::reply_status_t       rstat
);

  logic                       busy;
  logic                       is_reply;
  logic [sfpr_pkg::IDX_W-1:0] idx;
  logic [7:0]                 frame_byte;

  // Select the reply byte at the current position
  always_comb begin
    unique case (idx)
      sfpr_pkg::POS_U:    frame_byte = sfpr_pkg::CH_U;
      sfpr_pkg::POS_N:    frame_byte = sfpr_pkg::CH_N;
      sfpr_pkg::POS_E:    frame_byte = sfpr_pkg::CH_E;
      sfpr_pkg::POS_R:    frame_byte = sfpr_pkg::CH_R;
      sfpr_pkg::POS_TAG:  frame_byte = sfpr_pkg::REPLY_TAG;
      sfpr_pkg::POS_LHI:  frame_byte = sfpr_pkg::REPLY_LEN_HI;
      sfpr_pkg::POS_COL:  frame_byte = sfpr_pkg::CH_COLON;
      sfpr_pkg::POS_CMD:  frame_byte = sfpr_pkg::CMD_SEND;
      sfpr_pkg::POS_A_LO: frame_byte = status.chan_a[7:0];
      sfpr_pkg::POS_A_HI: frame_byte = status.chan_a[15:8];
      sfpr_pkg::POS_B_LO: frame_byte = status.chan_b[7:0];
      sfpr_pkg::POS_B_HI: frame_byte = status.chan_b[15:8];
      sfpr_pkg::POS_SUM:  frame_byte = sfpr_pkg::reply_sum(status.chan_a, status.chan_b);
      default:            frame_byte = 8'd0;
    endcase
  end

  // Drive the result beat
  assign out_valid = busy;
  assign tx_valid  = is_reply;
  assign tx_byte   = is_reply ? frame_byte : 8'd0;
  assign last      = !is_reply || (idx == sfpr_pkg::IDX_LAST);
  assign ack_flag  = status.ack;

  // Free for a new item when empty or when the final beat leaves now
  assign rstat.free = !busy || (last && !out_stall);

  // Load a new result, or advance through the reply burst
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      is_reply <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      busy     <= 1'b1;
      is_reply <= reply_req;
      idx      <= '0;
    end else if (busy && !out_stall) begin
      if (last) busy <= 1'b0;
      else idx <= idx + 1'b1;
    end
  end

endmodule

>>> design/serial_frame_parser_responder_top.sv
// Serial frame parser/responder: accepts one byte or ADC load per unstalled cycle and
// answers with a status beat or a 13-byte reply frame. Uses sfpr_pkg, sfpr_parser, sfpr_reply.
//
// Each input beat is registered, then handed to the parser once the result
// register is free. A received byte that does not complete a send request
// yields one result beat (tx_valid low, last high), so bytes stream at one
// per cycle while out_stall is low. A load beat, or a valid frame carrying the
// send command, yields a 13-beat reply frame; the result register then stays
// busy until its final beat has left, held longer by out_stall, while one further
// input beat waits in the input register. ack_flag on each result beat is the flag
// after that input was handled.
module serial_frame_parser_responder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] adc_first,
  input  logic [15:0] adc_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic        ack_flag
);

  logic                    s1_valid;
  logic                    s1_op;
  logic [7:0]              s1_byte;
  logic [15:0]             s1_adc_a;
  logic [15:0]             s1_adc_b;
  logic                    take;
  logic                    reply_req;
  sfpr_pkg::parse_status_t status;
  sfpr_pkg::reply_status_t rstat;

  // Hand the held beat on when the result register is free
  assign take     = s1_valid && rstat.free;
  assign in_stall = s1_valid && !rstat.free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op    <= op;
      s1_byte  <= rx_byte;
      s1_adc_a <= adc_first;
      s1_adc_b <= adc_second;
    end
  end

  sfpr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .op         (s1_op),
    .rx_byte    (s1_byte),
    .adc_first  (s1_adc_a),
    .adc_second (s1_adc_b),
    .reply_req  (reply_req),
    .status     (status)
  );

  sfpr_reply u_reply (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .reply_req (reply_req),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .last      (last),
    .ack_flag  (ack_flag),
    .rstat     (rstat)
  );

endmodule

>>> design/sfpr_checker.sv
// Port-level checks for the serial frame parser/responder, bound to the top.
// Depends on the top level's ports and on sfpr_pkg for the frame characters.
module sfpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       last
);

  // A status beat is always a single, final beat with a zero byte
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> last && tx_byte == 8'd0)
    else $error("status beat not final or byte not zero");

  // A reply burst continues with no gap once a non-final byte leaves
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && tx_valid && !last |=> out_valid && tx_valid)
    else $error("reply burst broken");

  // A reply frame opens with the sync letter after a status or final beat
  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last ##1 out_valid && tx_valid |-> tx_byte == sfpr_pkg::CH_U)
    else $error("reply frame does not start with sync byte");

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last))
    else $error("stalled result changed");

endmodule

bind serial_frame_parser_responder_top sfpr_checker u_sfpr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .tx_valid  (tx_valid),
  .tx_byte   (tx_byte),
  .last      (last)
);
